// ===== hw/rtl/acc_i2c_pkg.sv =====
package acc_i2c_pkg;

  localparam int unsigned RegisterCount = 64;
  localparam int unsigned TickWidth = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_TICK  = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_X_SAMPLE    = 3'd0,
    CFG_Y_SAMPLE    = 3'd1,
    CFG_Z_SAMPLE    = 3'd2,
    CFG_SLOW_PERIOD = 3'd3,
    CFG_FAST_PERIOD = 3'd4
  } cfg_idx_e;

  localparam logic [5:0] RegWhoAmI = 6'h0f;
  localparam logic [5:0] RegCtrl1  = 6'h20;
  localparam logic [5:0] RegCtrl2  = 6'h21;
  localparam logic [5:0] RegCtrl3  = 6'h22;
  localparam logic [5:0] RegStatus = 6'h27;
  localparam logic [5:0] RegOutX   = 6'h29;
  localparam logic [5:0] RegOutY   = 6'h2b;
  localparam logic [5:0] RegOutZ   = 6'h2d;
  localparam logic [5:0] RegFfCfg1 = 6'h30;
  localparam logic [5:0] RegFfSrc1 = 6'h31;
  localparam logic [5:0] RegFfCfg2 = 6'h34;
  localparam logic [5:0] RegFfSrc2 = 6'h35;
  localparam logic [7:0] WhoAmIVal = 8'h3b;
  localparam logic [7:0] Ctrl1Rst  = 8'h07;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       refused;
    logic       int1_level;
    logic       int2_level;
    logic       sampling_active;
  } out_beat_t;

  // classified operation from front to back
  typedef struct packed {
    mode_e      mode;
    logic       is_addr;
    logic       valid_ptr;
    logic [6:0] reg_addr;
    logic [7:0] data_byte;
  } op_t;

endpackage

// ===== hw/rtl/acc_i2c_front.sv =====
module acc_i2c_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  acc_i2c_pkg::in_beat_t in_data_i,
  output logic                op_valid_o,
  input  logic                op_stall_i,
  output acc_i2c_pkg::op_t    op_o
);

  logic [7:0] ptr_q, ptr_d;
  logic       ptr_vld_q, ptr_vld_d;
  logic       exp_q, exp_d;
  logic       acc;
  acc_i2c_pkg::op_t op;

  assign in_stall_o = op_stall_i;
  assign op_valid_o = in_valid_i;
  assign acc = in_valid_i && !op_stall_i;
  assign op_o = op;

  always_comb begin
    ptr_d = ptr_q;
    ptr_vld_d = ptr_vld_q;
    exp_d = exp_q;
    op.mode = acc_i2c_pkg::mode_e'(in_data_i.mode);
    op.data_byte = in_data_i.data_byte;
    op.is_addr = 1'b0;
    op.valid_ptr = ptr_vld_q;
    op.reg_addr = ptr_q[6:0];
    case (op.mode)
      acc_i2c_pkg::MODE_START: exp_d = 1'b1;
      acc_i2c_pkg::MODE_WRITE: begin
        if (exp_q) begin
          op.is_addr = 1'b1;
          exp_d = 1'b0;
          ptr_d = in_data_i.data_byte;
          ptr_vld_d = 1'b1;
        end else if (ptr_vld_q && ptr_q[7] && ptr_q != 8'hff) begin
          ptr_d = ptr_q + 8'd1;
        end
      end
      acc_i2c_pkg::MODE_READ: begin
        if (ptr_vld_q) begin
          if (ptr_q[7]) begin
            if (ptr_q != 8'hff) ptr_d = ptr_q + 8'd1;
          end else begin
            ptr_vld_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      ptr_vld_q <= 1'b0;
      exp_q <= 1'b0;
    end else if (acc) begin
      ptr_q <= ptr_d;
      ptr_vld_q <= ptr_vld_d;
      exp_q <= exp_d;
    end
  end

endmodule

// ===== hw/rtl/acc_i2c_queue.sv =====
module acc_i2c_queue #(
  parameter int unsigned Depth = acc_i2c_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_stall_o,
  input  acc_i2c_pkg::op_t wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_stall_i,
  output acc_i2c_pkg::op_t rd_data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  acc_i2c_pkg::op_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          push, pop;

  assign wr_stall_o = (cnt_q == (AW+1)'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign push = wr_valid_i && !wr_stall_o;
  assign pop = rd_valid_o && !rd_stall_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + AW'(1);
      if (pop) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ===== hw/rtl/acc_i2c_back.sv =====
module acc_i2c_back #(
  parameter int unsigned TickWidth = acc_i2c_pkg::TickWidth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [acc_i2c_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [acc_i2c_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                    op_valid_i,
  output logic                    op_stall_o,
  input  acc_i2c_pkg::op_t        op_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output acc_i2c_pkg::out_beat_t  out_data_o
);

  localparam logic [TickWidth-1:0] TickMax = '1;

  logic [7:0] regs_q [acc_i2c_pkg::RegisterCount];
  logic [7:0] regs_d [acc_i2c_pkg::RegisterCount];
  logic [7:0] xs_q, ys_q, zs_q;
  logic [15:0] slow_q, fast_q;
  logic [TickWidth-1:0] tick_q, tick_d, lim, tc;
  logic [15:0] per;
  logic arm_q, arm_d, l1_q, l1_d, l2_q, l2_d;
  logic ov_q;
  acc_i2c_pkg::out_beat_t ob_q, ob_d;
  logic acc, refresh;
  logic [3:0] nu;
  logic [7:0] st, c3, v;
  logic [5:0] r6;
  logic is_ro;

  assign op_stall_o = ov_q && out_stall_i;
  assign acc = op_valid_i && !op_stall_o;
  assign out_valid_o = ov_q;
  assign out_data_o = ob_q;

  function automatic logic mux_lvl(input logic [2:0] s, input logic [7:0] a,
                                   input logic [7:0] b, input logic [7:0] c);
    case (s)
      3'd1: mux_lvl = a[6];
      3'd2: mux_lvl = b[6];
      3'd3: mux_lvl = a[6] | b[6];
      3'd4: mux_lvl = c != 8'd0;
      default: mux_lvl = 1'b0;
    endcase
  endfunction

  always_comb begin
    regs_d = regs_q;
    tick_d = tick_q;
    arm_d = arm_q;
    refresh = 1'b0;
    ob_d = '0;
    r6 = op_i.reg_addr[5:0];
    nu = '0;
    st = '0;
    v = '0;
    per = regs_q[acc_i2c_pkg::RegCtrl1][7] ? fast_q : slow_q;
    if (per == 16'd0) per = 16'd1;
    if (TickWidth >= 16) lim = TickWidth'(per);
    else lim = (per > 16'(TickMax)) ? TickMax : TickWidth'(per);
    tc = (tick_q < TickMax) ? tick_q + TickWidth'(1) : tick_q;
    is_ro = 1'b0;
    case (op_i.mode)
      acc_i2c_pkg::MODE_WRITE: begin
        if (!op_i.is_addr) begin
          ob_d.refused = 1'b1;
          if (op_i.valid_ptr && !op_i.reg_addr[6]) begin
            case (r6)
              acc_i2c_pkg::RegCtrl1: begin
                ob_d.refused = 1'b0;
                regs_d[r6] = op_i.data_byte;
                arm_d = op_i.data_byte[6] && (op_i.data_byte[2:0] != 3'd0);
                if (arm_d && !arm_q) tick_d = '0;
              end
              acc_i2c_pkg::RegCtrl2: begin
                ob_d.refused = 1'b0;
                regs_d[r6] = op_i.data_byte & 8'hbf;
              end
              acc_i2c_pkg::RegCtrl3: begin
                ob_d.refused = 1'b0;
                regs_d[r6] = op_i.data_byte;
                refresh = 1'b1;
              end
              6'h30, 6'h32, 6'h33, 6'h34, 6'h36, 6'h37: begin
                ob_d.refused = 1'b0;
                regs_d[r6] = op_i.data_byte;
              end
              default: ;
            endcase
          end
        end
      end
      acc_i2c_pkg::MODE_READ: begin
        if (op_i.valid_ptr && !op_i.reg_addr[6]) begin
          v = regs_q[r6];
          is_ro = (r6 <= 6'h23) || r6 == acc_i2c_pkg::RegStatus ||
                  r6 == acc_i2c_pkg::RegOutX || r6 == acc_i2c_pkg::RegOutY ||
                  r6 == acc_i2c_pkg::RegOutZ || (r6 >= 6'h2e && r6 <= 6'h37);
          if (is_ro) ob_d.read_data = v;
          if ((r6 == acc_i2c_pkg::RegFfSrc1 || r6 == acc_i2c_pkg::RegFfSrc2) &&
              regs_q[r6 - 6'd1][6]) begin
            regs_d[r6] = 8'd0;
            refresh = 1'b1;
          end
        end
      end
      acc_i2c_pkg::MODE_TICK: begin
        if (arm_q) begin
          tick_d = tc;
          if (tc >= lim) begin
            tick_d = '0;
            nu = {1'b0, regs_q[acc_i2c_pkg::RegCtrl1][2:0]};
            if (nu == 4'd7) nu = 4'hf;
            st = regs_q[acc_i2c_pkg::RegStatus];
            regs_d[acc_i2c_pkg::RegStatus] = st | {4'd0, nu} | {st[3:0] & nu, 4'd0};
            if (nu[0]) regs_d[acc_i2c_pkg::RegOutX] = xs_q;
            if (nu[1]) regs_d[acc_i2c_pkg::RegOutY] = ys_q;
            if (nu[2]) regs_d[acc_i2c_pkg::RegOutZ] = zs_q;
            refresh = 1'b1;
          end
        end
      end
      default: ;
    endcase
    c3 = regs_d[acc_i2c_pkg::RegCtrl3];
    l1_d = l1_q;
    l2_d = l2_q;
    if (refresh) begin
      l1_d = mux_lvl(c3[2:0], regs_d[acc_i2c_pkg::RegFfSrc1],
                     regs_d[acc_i2c_pkg::RegFfSrc2], regs_d[acc_i2c_pkg::RegStatus]) ^ c3[7];
      l2_d = mux_lvl(c3[5:3], regs_d[acc_i2c_pkg::RegFfSrc1],
                     regs_d[acc_i2c_pkg::RegFfSrc2], regs_d[acc_i2c_pkg::RegStatus]) ^ c3[7];
    end
    ob_d.int1_level = l1_d;
    ob_d.int2_level = l2_d;
    ob_d.sampling_active = arm_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < acc_i2c_pkg::RegisterCount; i++) regs_q[i] <= 8'd0;
      regs_q[acc_i2c_pkg::RegWhoAmI] <= acc_i2c_pkg::WhoAmIVal;
      regs_q[acc_i2c_pkg::RegCtrl1] <= acc_i2c_pkg::Ctrl1Rst;
      tick_q <= '0;
      arm_q <= 1'b0;
      l1_q <= 1'b0;
      l2_q <= 1'b0;
      ov_q <= 1'b0;
      ob_q <= '0;
      xs_q <= 8'd0;
      ys_q <= 8'd0;
      zs_q <= 8'h10;
      slow_q <= 16'd10000;
      fast_q <= 16'd2500;
    end else begin
      if (cfg_we_i) begin
        case (acc_i2c_pkg::cfg_idx_e'(cfg_idx_i))
          acc_i2c_pkg::CFG_X_SAMPLE:    xs_q <= cfg_data_i[7:0];
          acc_i2c_pkg::CFG_Y_SAMPLE:    ys_q <= cfg_data_i[7:0];
          acc_i2c_pkg::CFG_Z_SAMPLE:    zs_q <= cfg_data_i[7:0];
          acc_i2c_pkg::CFG_SLOW_PERIOD: slow_q <= cfg_data_i;
          acc_i2c_pkg::CFG_FAST_PERIOD: fast_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (acc) begin
        regs_q <= regs_d;
        tick_q <= tick_d;
        arm_q <= arm_d;
        l1_q <= l1_d;
        l2_q <= l2_d;
        ob_q <= ob_d;
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/accel_i2c_register_model.sv =====
// Register file of a three-axis accelerometer behind an I2C slave link. Each input beat
// (write-start, write byte, read byte or time tick) yields one output beat; a beat can be
// taken every cycle while the output is not stalled. The front tracks the register pointer
// and classifies beats, a two-entry queue decouples it from the back, which does the
// read-modify-write of the register bytes and drives a registered output stage, so each
// result passes through a queue entry and then the output register.
module accel_i2c_register_model #(
  parameter int unsigned TickWidth = acc_i2c_pkg::TickWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [acc_i2c_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [acc_i2c_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  acc_i2c_pkg::in_beat_t             in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output acc_i2c_pkg::out_beat_t            out_data_o
);

  logic f_valid, f_stall, b_valid, b_stall;
  acc_i2c_pkg::op_t f_op, b_op;

  acc_i2c_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .op_valid_o(f_valid), .op_stall_i(f_stall), .op_o(f_op)
  );

  acc_i2c_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_stall_o(f_stall), .wr_data_i(f_op),
    .rd_valid_o(b_valid), .rd_stall_i(b_stall), .rd_data_o(b_op)
  );

  acc_i2c_back #(.TickWidth(TickWidth)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .op_valid_i(b_valid), .op_stall_o(b_stall), .op_i(b_op),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

// ===== hw/rtl/acc_i2c_checker.sv =====
module acc_i2c_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input acc_i2c_pkg::in_beat_t  in_data_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input acc_i2c_pkg::out_beat_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  a_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_stall_i |=> ##1 out_valid_o)
    else $error("accepted beat produced no result");

  a_refused_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.refused |-> out_data_o.read_data == 8'd0)
    else $error("refused beat carries read data");

endmodule

bind accel_i2c_register_model acc_i2c_checker u_checker (.*);

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [acc_i2c_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [acc_i2c_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  acc_i2c_pkg::in_beat_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  acc_i2c_pkg::out_beat_t out_data_o;

  accel_i2c_register_model DUT (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [7:0] regs [64];
  logic [7:0] ptr;
  logic ptr_ok, want_addr, armed, lvl1, lvl2;
  logic [15:0] ticks;
  logic [7:0] smp_x, smp_y, smp_z;
  logic [15:0] per_slow, per_fast;

  acc_i2c_pkg::out_beat_t beats_due [$];
  int errors = 0;
  int n_sent = 0, n_checked = 0, n_samples = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_off = 0;

  function automatic logic mux_pick(logic [2:0] sel);
    case (sel)
      3'd1: return regs[acc_i2c_pkg::RegFfSrc1][6];
      3'd2: return regs[acc_i2c_pkg::RegFfSrc2][6];
      3'd3: return regs[acc_i2c_pkg::RegFfSrc1][6] | regs[acc_i2c_pkg::RegFfSrc2][6];
      3'd4: return regs[acc_i2c_pkg::RegStatus] != 8'h00;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void relevel();
    logic inv;
    inv = regs[acc_i2c_pkg::RegCtrl3][7];
    lvl1 = mux_pick(regs[acc_i2c_pkg::RegCtrl3][2:0]) ^ inv;
    lvl2 = mux_pick(regs[acc_i2c_pkg::RegCtrl3][5:3]) ^ inv;
  endfunction

  function automatic void sample_now();
    logic [3:0] nu;
    logic [7:0] st;
    nu = {1'b0, regs[acc_i2c_pkg::RegCtrl1][2:0]};
    if (nu == 4'd7) nu = 4'hf;
    st = regs[acc_i2c_pkg::RegStatus];
    st = st | {4'h0, nu} | {(st[3:0] & nu), 4'h0};
    regs[acc_i2c_pkg::RegStatus] = st;
    if (nu[0]) regs[acc_i2c_pkg::RegOutX] = smp_x;
    if (nu[1]) regs[acc_i2c_pkg::RegOutY] = smp_y;
    if (nu[2]) regs[acc_i2c_pkg::RegOutZ] = smp_z;
    relevel();
    n_samples++;
  endfunction

  function automatic logic [7:0] target(logic is_rd);
    if (!ptr_ok) return 8'h80;
    target = {1'b0, ptr[6:0]};
    if (ptr[7]) begin
      if (ptr != 8'hff) ptr = ptr + 8'd1;
    end else if (is_rd) begin
      ptr_ok = 1'b0;
    end
  endfunction

  function automatic acc_i2c_pkg::out_beat_t predict_beat(acc_i2c_pkg::in_beat_t b);
    acc_i2c_pkg::out_beat_t r;
    logic [7:0] a;
    logic [15:0] lim;
    r = '0;
    case (acc_i2c_pkg::mode_e'(b.mode))
      acc_i2c_pkg::MODE_START: want_addr = 1'b1;
      acc_i2c_pkg::MODE_WRITE: begin
        if (want_addr) begin
          want_addr = 1'b0;
          ptr = b.data_byte;
          ptr_ok = 1'b1;
        end else begin
          a = target(1'b0);
          case (a)
            8'h20: begin
              logic arm;
              regs[acc_i2c_pkg::RegCtrl1] = b.data_byte;
              arm = b.data_byte[6] && (b.data_byte[2:0] != 3'd0);
              if (arm && !armed) ticks = '0;
              armed = arm;
            end
            8'h21: regs[acc_i2c_pkg::RegCtrl2] = b.data_byte & 8'hbf;
            8'h22: begin
              regs[acc_i2c_pkg::RegCtrl3] = b.data_byte;
              relevel();
            end
            8'h30, 8'h32, 8'h33, 8'h34, 8'h36, 8'h37: regs[a[5:0]] = b.data_byte;
            default: r.refused = 1'b1;
          endcase
        end
      end
      acc_i2c_pkg::MODE_READ: begin
        a = target(1'b1);
        if (a == 8'h31 || a == 8'h35) begin
          r.read_data = regs[a[5:0]];
          if (regs[a[5:0] - 6'd1][6]) begin
            regs[a[5:0]] = 8'h00;
            relevel();
          end
        end else if (a <= 8'h23 || a == 8'h27 || a == 8'h29 || a == 8'h2b ||
                     a == 8'h2d || (a >= 8'h2e && a <= 8'h37)) begin
          r.read_data = regs[a[5:0]];
        end
      end
      default: begin
        if (armed) begin
          lim = regs[acc_i2c_pkg::RegCtrl1][7] ? per_fast : per_slow;
          if (lim == 16'd0) lim = 16'd1;
          if (ticks != 16'hffff) ticks = ticks + 16'd1;
          if (ticks >= lim) begin
            ticks = '0;
            sample_now();
          end
        end
      end
    endcase
    r.int1_level = lvl1;
    r.int2_level = lvl2;
    r.sampling_active = armed;
    return r;
  endfunction

  task automatic predictor_reset();
    foreach (regs[i]) regs[i] = 8'h00;
    regs[acc_i2c_pkg::RegWhoAmI] = acc_i2c_pkg::WhoAmIVal;
    regs[acc_i2c_pkg::RegCtrl1] = acc_i2c_pkg::Ctrl1Rst;
    ptr = '0;
    ptr_ok = 0;
    want_addr = 0;
    armed = 0;
    lvl1 = 0;
    lvl2 = 0;
    ticks = '0;
    smp_x = 8'h00;
    smp_y = 8'h00;
    smp_z = 8'h10;
    per_slow = 16'd10000;
    per_fast = 16'd2500;
  endtask

  // valid stays high after a beat so the next one can follow at once
  task automatic send_beat(logic [1:0] m, logic [7:0] d);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{mode: m, data_byte: d};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_due.push_back(predict_beat('{mode: m, data_byte: d}));
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(acc_i2c_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      acc_i2c_pkg::CFG_X_SAMPLE: smp_x = val[7:0];
      acc_i2c_pkg::CFG_Y_SAMPLE: smp_y = val[7:0];
      acc_i2c_pkg::CFG_Z_SAMPLE: smp_z = val[7:0];
      acc_i2c_pkg::CFG_SLOW_PERIOD: per_slow = val;
      default: per_fast = val;
    endcase
    @(posedge clk_i);
  endtask

  task automatic reg_write(logic [7:0] p, logic [7:0] d);
    send_beat(acc_i2c_pkg::MODE_START, 8'h00);
    send_beat(acc_i2c_pkg::MODE_WRITE, p);
    send_beat(acc_i2c_pkg::MODE_WRITE, d);
  endtask

  task automatic reg_read(logic [7:0] p);
    send_beat(acc_i2c_pkg::MODE_START, 8'h00);
    send_beat(acc_i2c_pkg::MODE_WRITE, p);
    send_beat(acc_i2c_pkg::MODE_READ, 8'h00);
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_off) out_stall_i <= 1'b1;
      else out_stall_i <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      acc_i2c_pkg::out_beat_t e;
      if (beats_due.size() == 0) begin
        $error("unexpected beat %h", out_data_o);
        errors++;
      end else begin
        e = beats_due.pop_front();
        n_checked++;
        if (out_data_o.read_data !== e.read_data) begin
          $error("read_data exp %h got %h", e.read_data, out_data_o.read_data); errors++; end
        if (out_data_o.refused !== e.refused) begin
          $error("refused exp %b got %b", e.refused, out_data_o.refused); errors++; end
        if (out_data_o.int1_level !== e.int1_level) begin
          $error("int1_level exp %b got %b", e.int1_level, out_data_o.int1_level); errors++; end
        if (out_data_o.int2_level !== e.int2_level) begin
          $error("int2_level exp %b got %b", e.int2_level, out_data_o.int2_level); errors++; end
        if (out_data_o.sampling_active !== e.sampling_active) begin
          $error("sampling_active exp %b got %b", e.sampling_active,
                 out_data_o.sampling_active);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_beat(acc_i2c_pkg::MODE_WRITE, 8'h20);     // no pointer yet
    send_beat(acc_i2c_pkg::MODE_READ, 8'h00);
    send_beat(acc_i2c_pkg::MODE_TICK, 8'hff);      // stopped tick
    reg_read(8'h0f);
    send_beat(acc_i2c_pkg::MODE_READ, 8'h00);      // pointer now invalid
    reg_write(8'h05, 8'h55);                       // protected
    reg_write(8'h2e, 8'haa);
    reg_write(8'h7f, 8'hff);                       // unknown
    reg_write(8'h21, 8'hff);
    reg_read(8'h21);
    send_beat(acc_i2c_pkg::MODE_START, 8'h00);     // read while address pending
    send_beat(acc_i2c_pkg::MODE_READ, 8'h00);
    send_beat(acc_i2c_pkg::MODE_WRITE, 8'hfe);     // auto-inc near end
    send_beat(acc_i2c_pkg::MODE_READ, 8'h00);
    send_beat(acc_i2c_pkg::MODE_READ, 8'h00);
    send_beat(acc_i2c_pkg::MODE_WRITE, 8'h00);
  endtask

  task automatic test_sampling(logic [15:0] slow, logic [15:0] fast);
    write_cfg(acc_i2c_pkg::CFG_X_SAMPLE, 16'($urandom_range(255)));
    write_cfg(acc_i2c_pkg::CFG_Y_SAMPLE, 16'($urandom_range(255)));
    write_cfg(acc_i2c_pkg::CFG_Z_SAMPLE, 16'($urandom_range(255)));
    write_cfg(acc_i2c_pkg::CFG_SLOW_PERIOD, slow);
    write_cfg(acc_i2c_pkg::CFG_FAST_PERIOD, fast);
    reg_write(8'h20, 8'hc7);
    reg_write(8'h30, 8'h40);
    reg_write(8'h34, 8'h40);
    reg_write(8'h22, 8'h0c);
    repeat (6) send_beat(acc_i2c_pkg::MODE_TICK, 8'h00);
    reg_write(8'h22, 8'h9a);
    reg_read(8'ha7);
    send_beat(acc_i2c_pkg::MODE_READ, 8'h00);
    send_beat(acc_i2c_pkg::MODE_READ, 8'h00);
    reg_write(8'h20, 8'h00);
    send_beat(acc_i2c_pkg::MODE_TICK, 8'h00);
    wait_drained();
  endtask

  task automatic random_beat();
    int k;
    logic [7:0] regsel [12] = '{8'h20, 8'h21, 8'h22, 8'h27, 8'h29, 8'h30, 8'h31,
                                8'h34, 8'h35, 8'h0f, 8'h2d, 8'h7f};
    k = $urandom_range(99);
    if (k < 40) begin
      send_beat(acc_i2c_pkg::MODE_TICK, 8'($urandom));
    end else if (k < 80) begin
      logic [7:0] p;
      p = {1'($urandom), regsel[$urandom_range(11)][6:0]};
      if ($urandom_range(3) == 0) p = 8'($urandom);
      send_beat(acc_i2c_pkg::MODE_START, 8'($urandom));
      send_beat(acc_i2c_pkg::MODE_WRITE, p);
      if ($urandom_range(1)) send_beat(acc_i2c_pkg::MODE_WRITE, 8'($urandom));
      else send_beat(acc_i2c_pkg::MODE_READ, 8'($urandom));
    end else begin
      send_beat(2'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_random(int count, int s_idle, int r_stall);
    send_idle = s_idle;
    recv_stall = r_stall;
    write_cfg(acc_i2c_pkg::CFG_SLOW_PERIOD, 16'($urandom_range(1, 6)));
    write_cfg(acc_i2c_pkg::CFG_FAST_PERIOD, 16'($urandom_range(1, 4)));
    write_cfg(acc_i2c_pkg::CFG_X_SAMPLE, 16'($urandom));
    reg_write(8'h20, {1'($urandom), 7'h47});
    while (count > 0) begin
      random_beat();
      count -= 2;
    end
    wait_drained();
    send_idle = 0;
    recv_stall = 0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (60) @(posedge clk_i);
        hold_off = 0;
      end
      begin
        repeat (20) send_beat(acc_i2c_pkg::MODE_TICK, 8'h00);
        in_valid_i <= 1'b0;
      end
    join
    wait_drained();
  endtask

  initial begin
    predictor_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    test_sampling(16'd1, 16'd2);
    test_sampling(16'd0, 16'd0);
    test_sampling(16'hffff, 16'hffff);
    test_sampling(16'd3, 16'd1);
    test_random(260, 0, 0);
    test_random(260, 71, 0);
    test_random(260, 0, 71);
    test_random(260, 6, 6);
    test_backpressure();
    $display("sent %0d beats, checked %0d, %0d samples taken", n_sent, n_checked,
             n_samples);
    if (errors == 0 && beats_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== accel_i2c_register_model.f =====
hw/rtl/acc_i2c_pkg.sv
hw/rtl/acc_i2c_front.sv
hw/rtl/acc_i2c_queue.sv
hw/rtl/acc_i2c_back.sv
hw/rtl/accel_i2c_register_model.sv
hw/rtl/acc_i2c_checker.sv
verif/tb_top.sv
